// File: rtl/i2cmra_pkg.sv
package i2cmra_pkg;

  // Request kinds carried on the input tuser
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [3:0]  BITS_PER_BYTE = 4'd8;
  localparam logic [7:0]  MSB_MASK = 8'h80;
  localparam logic [7:0]  READ_BIT = 8'h01;

  // Bus phases, one-hot
  typedef enum logic [20:0] {
    PH_IDLE      = 21'h000001,
    PH_START_LOW = 21'h000002,
    PH_TX_LOW    = 21'h000004,
    PH_TX_DATA   = 21'h000008,
    PH_TX_HIGH   = 21'h000010,
    PH_ACK_LOW   = 21'h000020,
    PH_ACK_REL   = 21'h000040,
    PH_ACK_HIGH  = 21'h000080,
    PH_RS_LOW    = 21'h000100,
    PH_RS_HIGH   = 21'h000200,
    PH_RS_FALL   = 21'h000400,
    PH_RX_LOW    = 21'h000800,
    PH_RX_HIGH   = 21'h001000,
    PH_MA_LOW    = 21'h002000,
    PH_MA_SET    = 21'h004000,
    PH_MA_HIGH   = 21'h008000,
    PH_MA_END    = 21'h010000,
    PH_SP_LOW    = 21'h020000,
    PH_SP_SDA    = 21'h040000,
    PH_SP_HIGH   = 21'h080000,
    PH_SP_END    = 21'h100000
  } phase_t;

  // Byte in flight
  typedef enum logic [3:0] {
    STG_ADDR  = 4'b0001,
    STG_REG   = 4'b0010,
    STG_DATA  = 4'b0100,
    STG_RADDR = 4'b1000
  } stage_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] slave_address;
    logic [7:0] register_address;
    logic [7:0] write_byte;
    logic [7:0] read_count;
    logic       sda_in;
  } tick_req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       last_byte;
    logic       done_res;
    logic       success;
    logic       busy_res;
  } tick_res_t;

endpackage

// File: rtl/i2cmra_seq.sv
module i2cmra_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  i2cmra_pkg::tick_req_t req,
  output i2cmra_pkg::tick_res_t res
);

  i2cmra_pkg::phase_t phase_r, phase_nxt;
  i2cmra_pkg::stage_t stage_r, stage_nxt;
  logic [3:0] bit_count_r, bit_count_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] held_addr_r, held_addr_nxt;
  logic [7:0] held_reg_r, held_reg_nxt;
  logic [7:0] held_data_r, held_data_nxt;
  logic       is_read_r, is_read_nxt;
  logic       failed_r, failed_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic [3:0] bit_inc;
  logic [7:0] rx_shift;
  logic [7:0] bytes_dec;

  assign bit_inc   = bit_count_r + 4'd1;
  assign rx_shift  = {shift_r[6:0], req.sda_in};
  assign bytes_dec = (bytes_left_r != 8'd0) ? bytes_left_r - 8'd1 : bytes_left_r;

  always_comb begin
    phase_nxt      = phase_r;
    stage_nxt      = stage_r;
    bit_count_nxt  = bit_count_r;
    shift_nxt      = shift_r;
    bytes_left_nxt = bytes_left_r;
    held_addr_nxt  = held_addr_r;
    held_reg_nxt   = held_reg_r;
    held_data_nxt  = held_data_r;
    is_read_nxt    = is_read_r;
    failed_nxt     = failed_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    res            = '0;

    case (phase_r)
      i2cmra_pkg::PH_START_LOW: begin
        sda_nxt       = 1'b0;
        stage_nxt     = i2cmra_pkg::STG_ADDR;
        shift_nxt     = held_addr_r;
        bit_count_nxt = 4'd0;
        phase_nxt     = i2cmra_pkg::PH_TX_LOW;
      end
      i2cmra_pkg::PH_TX_LOW: begin
        scl_nxt   = 1'b0;
        phase_nxt = i2cmra_pkg::PH_TX_DATA;
      end
      i2cmra_pkg::PH_TX_DATA: begin
        sda_nxt   = |(shift_r & i2cmra_pkg::MSB_MASK);
        shift_nxt = {shift_r[6:0], 1'b0};
        phase_nxt = i2cmra_pkg::PH_TX_HIGH;
      end
      i2cmra_pkg::PH_TX_HIGH: begin
        scl_nxt       = 1'b1;
        bit_count_nxt = bit_inc;
        phase_nxt     = (bit_inc >= i2cmra_pkg::BITS_PER_BYTE) ?
                        i2cmra_pkg::PH_ACK_LOW : i2cmra_pkg::PH_TX_LOW;
      end
      i2cmra_pkg::PH_ACK_LOW: begin
        scl_nxt   = 1'b0;
        phase_nxt = i2cmra_pkg::PH_ACK_REL;
      end
      i2cmra_pkg::PH_ACK_REL: begin
        sda_nxt   = 1'b1;
        phase_nxt = i2cmra_pkg::PH_ACK_HIGH;
      end
      i2cmra_pkg::PH_ACK_HIGH: begin
        scl_nxt = 1'b1;
        case (stage_r)
          i2cmra_pkg::STG_ADDR: begin
            if (req.sda_in) begin
              failed_nxt = 1'b1;
              phase_nxt  = i2cmra_pkg::PH_SP_LOW;
            end else begin
              stage_nxt     = i2cmra_pkg::STG_REG;
              shift_nxt     = held_reg_r;
              bit_count_nxt = 4'd0;
              phase_nxt     = i2cmra_pkg::PH_TX_LOW;
            end
          end
          i2cmra_pkg::STG_REG: begin
            if (is_read_r) begin
              phase_nxt = i2cmra_pkg::PH_RS_LOW;
            end else begin
              stage_nxt     = i2cmra_pkg::STG_DATA;
              shift_nxt     = held_data_r;
              bit_count_nxt = 4'd0;
              phase_nxt     = i2cmra_pkg::PH_TX_LOW;
            end
          end
          i2cmra_pkg::STG_DATA: begin
            phase_nxt = i2cmra_pkg::PH_SP_LOW;
          end
          default: begin
            if (bytes_left_r == 8'd0) begin
              phase_nxt = i2cmra_pkg::PH_SP_LOW;
            end else begin
              shift_nxt     = 8'd0;
              bit_count_nxt = 4'd0;
              phase_nxt     = i2cmra_pkg::PH_RX_LOW;
            end
          end
        endcase
      end
      i2cmra_pkg::PH_RS_LOW: begin
        scl_nxt   = 1'b0;
        sda_nxt   = 1'b1;
        phase_nxt = i2cmra_pkg::PH_RS_HIGH;
      end
      i2cmra_pkg::PH_RS_HIGH: begin
        scl_nxt   = 1'b1;
        phase_nxt = i2cmra_pkg::PH_RS_FALL;
      end
      i2cmra_pkg::PH_RS_FALL: begin
        sda_nxt       = 1'b0;
        stage_nxt     = i2cmra_pkg::STG_RADDR;
        shift_nxt     = held_addr_r | i2cmra_pkg::READ_BIT;
        bit_count_nxt = 4'd0;
        phase_nxt     = i2cmra_pkg::PH_TX_LOW;
      end
      i2cmra_pkg::PH_RX_LOW: begin
        scl_nxt   = 1'b0;
        sda_nxt   = 1'b1;
        phase_nxt = i2cmra_pkg::PH_RX_HIGH;
      end
      i2cmra_pkg::PH_RX_HIGH: begin
        scl_nxt       = 1'b1;
        shift_nxt     = rx_shift;
        bit_count_nxt = bit_inc;
        if (bit_inc >= i2cmra_pkg::BITS_PER_BYTE) begin
          res.read_byte  = rx_shift;
          res.read_valid = 1'b1;
          res.last_byte  = (bytes_left_r == 8'd1);
          phase_nxt      = i2cmra_pkg::PH_MA_LOW;
        end else begin
          phase_nxt = i2cmra_pkg::PH_RX_LOW;
        end
      end
      i2cmra_pkg::PH_MA_LOW: begin
        scl_nxt   = 1'b0;
        phase_nxt = i2cmra_pkg::PH_MA_SET;
      end
      i2cmra_pkg::PH_MA_SET: begin
        // nack the final byte, ack the rest
        sda_nxt   = (bytes_left_r <= 8'd1);
        phase_nxt = i2cmra_pkg::PH_MA_HIGH;
      end
      i2cmra_pkg::PH_MA_HIGH: begin
        scl_nxt   = 1'b1;
        phase_nxt = i2cmra_pkg::PH_MA_END;
      end
      i2cmra_pkg::PH_MA_END: begin
        scl_nxt        = 1'b0;
        bytes_left_nxt = bytes_dec;
        if (bytes_dec == 8'd0) begin
          phase_nxt = i2cmra_pkg::PH_SP_LOW;
        end else begin
          shift_nxt     = 8'd0;
          bit_count_nxt = 4'd0;
          phase_nxt     = i2cmra_pkg::PH_RX_LOW;
        end
      end
      i2cmra_pkg::PH_SP_LOW: begin
        scl_nxt   = 1'b0;
        phase_nxt = i2cmra_pkg::PH_SP_SDA;
      end
      i2cmra_pkg::PH_SP_SDA: begin
        sda_nxt   = 1'b0;
        phase_nxt = i2cmra_pkg::PH_SP_HIGH;
      end
      i2cmra_pkg::PH_SP_HIGH: begin
        scl_nxt   = 1'b1;
        phase_nxt = i2cmra_pkg::PH_SP_END;
      end
      i2cmra_pkg::PH_SP_END: begin
        sda_nxt     = 1'b1;
        res.done_res = 1'b1;
        res.success  = ~failed_r;
        phase_nxt   = i2cmra_pkg::PH_IDLE;
      end
      default: begin
        phase_nxt = i2cmra_pkg::PH_IDLE;
        if (req.kind == i2cmra_pkg::KIND_WRITE || req.kind == i2cmra_pkg::KIND_READ) begin
          held_addr_nxt  = req.slave_address;
          held_reg_nxt   = req.register_address;
          held_data_nxt  = req.write_byte;
          bytes_left_nxt = req.read_count;
          is_read_nxt    = (req.kind == i2cmra_pkg::KIND_READ);
          failed_nxt     = 1'b0;
          stage_nxt      = i2cmra_pkg::STG_ADDR;
          bit_count_nxt  = 4'd0;
          shift_nxt      = 8'd0;
          scl_nxt        = 1'b1;
          sda_nxt        = 1'b1;
          if (!req.sda_in) begin
            // bus held low by someone else: fail at once, no stop
            res.done_res = 1'b1;
          end else begin
            phase_nxt = i2cmra_pkg::PH_START_LOW;
          end
        end
      end
    endcase

    res.scl_level = scl_nxt;
    res.sda_level = sda_nxt;
    res.busy_res  = (phase_nxt != i2cmra_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= i2cmra_pkg::PH_IDLE;
      stage_r      <= i2cmra_pkg::STG_ADDR;
      bit_count_r  <= 4'd0;
      shift_r      <= 8'd0;
      bytes_left_r <= 8'd0;
      held_addr_r  <= 8'd0;
      held_reg_r   <= 8'd0;
      held_data_r  <= 8'd0;
      is_read_r    <= 1'b0;
      failed_r     <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
    end else if (step) begin
      phase_r      <= phase_nxt;
      stage_r      <= stage_nxt;
      bit_count_r  <= bit_count_nxt;
      shift_r      <= shift_nxt;
      bytes_left_r <= bytes_left_nxt;
      held_addr_r  <= held_addr_nxt;
      held_reg_r   <= held_reg_nxt;
      held_data_r  <= held_data_nxt;
      is_read_r    <= is_read_nxt;
      failed_r     <= failed_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == i2cmra_pkg::PH_IDLE) |-> (scl_r && sda_r))
    else $error("bus not released while idle");

  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == i2cmra_pkg::PH_TX_HIGH || phase_r == i2cmra_pkg::PH_RX_HIGH)
      |-> (bit_count_r < i2cmra_pkg::BITS_PER_BYTE))
    else $error("bit counter ran past a byte");

  assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == i2cmra_pkg::PH_TX_DATA) |=> !scl_r)
    else $error("SDA changed while SCL released");

endmodule

// File: rtl/i2c_master_register_access_top.sv
// Channel   | handshake               | tdata / tuser / tlast
// ----------+-------------------------+------------------------------------------
// in_       | in_tvalid / in_tready   | tdata: addr, reg, wbyte, count, sda_in
//           |                         | tuser: kind
// out_      | out_tvalid / out_tready | tdata: scl, sda, rbyte, rvalid, done,
//           |                         | success, busy; tlast: last_byte
//
// Each request (one bus tick) is taken on its handshake and its result appears in
// the output register on the next cycle; one request per cycle is sustained while
// out_tready is high. That register loads the combinational sequencer update.
// A new request is taken while the current result is being taken in the same cycle.
// Reset (rst_n low, synchronous) idles the sequencer and releases SCL and SDA.
// A stalled result holds the output and blocks input until it is taken.
module i2c_master_register_access_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] slave_address, [15:8] register_address, [23:16] write_byte,
  // [31:24] read_count, [32] sda_in, [39:33] zero
  input  logic [39:0] in_tdata,
  // [1:0] kind
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] scl_level, [1] sda_level, [9:2] read_byte, [10] read_valid,
  // [11] done_res, [12] success, [13] busy_res, [15:14] zero
  output logic [15:0] out_tdata,
  output logic        out_tlast
);

  i2cmra_pkg::tick_req_t req;
  i2cmra_pkg::tick_res_t res;
  logic                  step;
  logic                  out_valid_r;
  logic [15:0]           out_data_r;
  logic                  out_last_r;

  // take a request whenever the output slot is free or being emptied
  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  assign req.kind             = in_tuser;
  assign req.slave_address    = in_tdata[7:0];
  assign req.register_address = in_tdata[15:8];
  assign req.write_byte       = in_tdata[23:16];
  assign req.read_count       = in_tdata[31:24];
  assign req.sda_in           = in_tdata[32];

  i2cmra_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .req   (req),
    .res   (res)
  );

  // output register: valid is control, payload loads on each request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= {2'b00, res.busy_res, res.success, res.done_res, res.read_valid,
                     res.read_byte, res.sda_level, res.scl_level};
      out_last_r <= res.last_byte;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[12]) |-> out_tdata[11])
    else $error("success flagged without done");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[11]) |-> !out_tdata[13])
    else $error("busy still set on done tick");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tdata[10])
    else $error("last byte without a received byte");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[10]) |-> (out_tdata[0] && !out_tdata[11]))
    else $error("byte received outside SCL high");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("request taken over a stalled result");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  // Kind 3 has no meaning to the sequencer and must act as a plain tick
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam int unsigned RANDOM_TICKS = 150;
  localparam int unsigned DRAIN_LIMIT  = 5000;
  localparam int unsigned MAX_PRINTS   = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = i2cmra_pkg::KIND_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;

  i2c_master_register_access_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted per-tick results, oldest first
  i2cmra_pkg::tick_res_t pending_results[$];
  int unsigned err_count = 0;
  int unsigned result_count = 0;
  int unsigned tick_count = 0;

  // Run summary
  int unsigned writes_done = 0;
  int unsigned reads_done = 0;
  int unsigned refused = 0;
  int unsigned bytes_rx = 0;

  // Slave behavior knobs: chance (percent) that a start finds SDA low,
  // and that the address ack comes back as NACK
  int unsigned busy_pct = 0;
  int unsigned nack_pct = 0;

  // Flow control knobs
  bit          gaps_on = 1'b0;
  bit          stalls_on = 1'b0;
  int unsigned burst_left = 0;
  int unsigned hold_kick = 0;
  int unsigned hold_len = 0;

  // -------------------------------------------------------------------------
  // Bus sequencer shadow: phase, byte in flight, shifter and held operands
  // -------------------------------------------------------------------------
  i2cmra_pkg::phase_t bus_phase;
  i2cmra_pkg::stage_t bus_stage;
  logic [3:0] bits_done;
  logic [7:0] shreg;
  logic [7:0] bytes_rem;
  logic [7:0] addr_q;
  logic [7:0] reg_q;
  logic [7:0] data_q;
  logic       rd_q;
  logic       scl_q;
  logic       sda_q;
  logic       fail_q;

  function void bus_reset();
    bus_phase = i2cmra_pkg::PH_IDLE;
    bus_stage = i2cmra_pkg::STG_ADDR;
    bits_done = '0;
    shreg     = '0;
    bytes_rem = '0;
    addr_q    = '0;
    reg_q     = '0;
    data_q    = '0;
    rd_q      = 1'b0;
    scl_q     = 1'b1;
    sda_q     = 1'b1;
    fail_q    = 1'b0;
  endfunction

  function void load_tx(logic [7:0] value);
    shreg     = value;
    bits_done = '0;
    bus_phase = i2cmra_pkg::PH_TX_LOW;
  endfunction

  function void load_rx();
    shreg     = '0;
    bits_done = '0;
    bus_phase = i2cmra_pkg::PH_RX_LOW;
  endfunction

  // Advance the shadow by one tick and return what the block must show
  function i2cmra_pkg::tick_res_t bus_step(i2cmra_pkg::tick_req_t r);
    i2cmra_pkg::tick_res_t e;
    e = '0;
    case (bus_phase)
      i2cmra_pkg::PH_START_LOW: begin
        sda_q     = 1'b0;
        bus_stage = i2cmra_pkg::STG_ADDR;
        load_tx(addr_q);
      end
      i2cmra_pkg::PH_TX_LOW: begin
        scl_q     = 1'b0;
        bus_phase = i2cmra_pkg::PH_TX_DATA;
      end
      i2cmra_pkg::PH_TX_DATA: begin
        sda_q     = shreg[7];
        shreg     = {shreg[6:0], 1'b0};
        bus_phase = i2cmra_pkg::PH_TX_HIGH;
      end
      i2cmra_pkg::PH_TX_HIGH: begin
        scl_q     = 1'b1;
        bits_done = bits_done + 4'd1;
        bus_phase = (bits_done >= i2cmra_pkg::BITS_PER_BYTE) ?
                    i2cmra_pkg::PH_ACK_LOW : i2cmra_pkg::PH_TX_LOW;
      end
      i2cmra_pkg::PH_ACK_LOW: begin
        scl_q     = 1'b0;
        bus_phase = i2cmra_pkg::PH_ACK_REL;
      end
      i2cmra_pkg::PH_ACK_REL: begin
        sda_q     = 1'b1;
        bus_phase = i2cmra_pkg::PH_ACK_HIGH;
      end
      i2cmra_pkg::PH_ACK_HIGH: begin
        scl_q = 1'b1;
        case (bus_stage)
          i2cmra_pkg::STG_ADDR: begin
            if (r.sda_in) begin
              fail_q    = 1'b1;
              bus_phase = i2cmra_pkg::PH_SP_LOW;
            end else begin
              bus_stage = i2cmra_pkg::STG_REG;
              load_tx(reg_q);
            end
          end
          i2cmra_pkg::STG_REG: begin
            if (rd_q) begin
              bus_phase = i2cmra_pkg::PH_RS_LOW;
            end else begin
              bus_stage = i2cmra_pkg::STG_DATA;
              load_tx(data_q);
            end
          end
          i2cmra_pkg::STG_DATA: bus_phase = i2cmra_pkg::PH_SP_LOW;
          default: begin
            if (bytes_rem == 8'd0) bus_phase = i2cmra_pkg::PH_SP_LOW;
            else load_rx();
          end
        endcase
      end
      i2cmra_pkg::PH_RS_LOW: begin
        scl_q     = 1'b0;
        sda_q     = 1'b1;
        bus_phase = i2cmra_pkg::PH_RS_HIGH;
      end
      i2cmra_pkg::PH_RS_HIGH: begin
        scl_q     = 1'b1;
        bus_phase = i2cmra_pkg::PH_RS_FALL;
      end
      i2cmra_pkg::PH_RS_FALL: begin
        sda_q     = 1'b0;
        bus_stage = i2cmra_pkg::STG_RADDR;
        load_tx(addr_q | i2cmra_pkg::READ_BIT);
      end
      i2cmra_pkg::PH_RX_LOW: begin
        scl_q     = 1'b0;
        sda_q     = 1'b1;
        bus_phase = i2cmra_pkg::PH_RX_HIGH;
      end
      i2cmra_pkg::PH_RX_HIGH: begin
        scl_q     = 1'b1;
        shreg     = {shreg[6:0], r.sda_in};
        bits_done = bits_done + 4'd1;
        if (bits_done >= i2cmra_pkg::BITS_PER_BYTE) begin
          e.read_byte  = shreg;
          e.read_valid = 1'b1;
          e.last_byte  = (bytes_rem == 8'd1);
          bus_phase    = i2cmra_pkg::PH_MA_LOW;
        end else begin
          bus_phase = i2cmra_pkg::PH_RX_LOW;
        end
      end
      i2cmra_pkg::PH_MA_LOW: begin
        scl_q     = 1'b0;
        bus_phase = i2cmra_pkg::PH_MA_SET;
      end
      i2cmra_pkg::PH_MA_SET: begin
        // ACK every byte but the final one, which gets NACK
        sda_q     = (bytes_rem <= 8'd1);
        bus_phase = i2cmra_pkg::PH_MA_HIGH;
      end
      i2cmra_pkg::PH_MA_HIGH: begin
        scl_q     = 1'b1;
        bus_phase = i2cmra_pkg::PH_MA_END;
      end
      i2cmra_pkg::PH_MA_END: begin
        scl_q = 1'b0;
        if (bytes_rem > 8'd0) bytes_rem = bytes_rem - 8'd1;
        if (bytes_rem == 8'd0) bus_phase = i2cmra_pkg::PH_SP_LOW;
        else load_rx();
      end
      i2cmra_pkg::PH_SP_LOW: begin
        scl_q     = 1'b0;
        bus_phase = i2cmra_pkg::PH_SP_SDA;
      end
      i2cmra_pkg::PH_SP_SDA: begin
        sda_q     = 1'b0;
        bus_phase = i2cmra_pkg::PH_SP_HIGH;
      end
      i2cmra_pkg::PH_SP_HIGH: begin
        scl_q     = 1'b1;
        bus_phase = i2cmra_pkg::PH_SP_END;
      end
      i2cmra_pkg::PH_SP_END: begin
        sda_q      = 1'b1;
        e.done_res = 1'b1;
        e.success  = !fail_q;
        bus_phase  = i2cmra_pkg::PH_IDLE;
      end
      default: begin
        // Idle: only a write or read request starts anything
        bus_phase = i2cmra_pkg::PH_IDLE;
        if (r.kind == i2cmra_pkg::KIND_WRITE || r.kind == i2cmra_pkg::KIND_READ) begin
          addr_q    = r.slave_address;
          reg_q     = r.register_address;
          data_q    = r.write_byte;
          bytes_rem = r.read_count;
          rd_q      = (r.kind == i2cmra_pkg::KIND_READ);
          fail_q    = 1'b0;
          bus_stage = i2cmra_pkg::STG_ADDR;
          bits_done = '0;
          shreg     = '0;
          scl_q     = 1'b1;
          sda_q     = 1'b1;
          if (!r.sda_in) begin
            // Bus busy: fail on the spot, no stop
            e.done_res = 1'b1;
            e.success  = 1'b0;
          end else begin
            bus_phase = i2cmra_pkg::PH_START_LOW;
          end
        end
      end
    endcase
    e.scl_level = scl_q;
    e.sda_level = sda_q;
    e.busy_res  = (bus_phase != i2cmra_pkg::PH_IDLE);
    return e;
  endfunction

  // Choose the SDA level the slave presents on this tick
  function automatic logic pick_sda(logic [1:0] kind);
    if (bus_phase == i2cmra_pkg::PH_IDLE &&
        (kind == i2cmra_pkg::KIND_WRITE || kind == i2cmra_pkg::KIND_READ))
      return ($urandom_range(99) >= busy_pct);
    if (bus_phase == i2cmra_pkg::PH_ACK_HIGH && bus_stage == i2cmra_pkg::STG_ADDR)
      return ($urandom_range(99) < nack_pct);
    return 1'($urandom);
  endfunction

  // -------------------------------------------------------------------------
  // Request driver: offer one tick, wait for the handshake, then predict
  // -------------------------------------------------------------------------
  task automatic offer_tick(input logic [1:0] kind, input logic [7:0] addr,
                            input logic [7:0] reg_addr, input logic [7:0] wbyte,
                            input logic [7:0] count);
    i2cmra_pkg::tick_req_t r;
    i2cmra_pkg::tick_res_t e;
    int unsigned gap;
    r.kind             = kind;
    r.slave_address    = addr;
    r.register_address = reg_addr;
    r.write_byte       = wbyte;
    r.read_count       = count;
    r.sda_in           = pick_sda(kind);
    // Drop valid between bursts
    if (gaps_on && burst_left == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_tdata  <= {7'b0, r.sda_in, r.read_count, r.write_byte,
                  r.register_address, r.slave_address};
    in_tuser  <= r.kind;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    e = bus_step(r);
    pending_results.push_back(e);
    tick_count++;
    if (e.read_valid) bytes_rx++;
    if (e.done_res) begin
      if (!e.success) refused++;
      else if (rd_q) reads_done++;
      else writes_done++;
    end
  endtask

  // Start a transfer, then keep ticking until the sequencer is idle again.
  // Filler ticks carry random kinds, so requests while busy get exercised.
  task automatic run_transfer(input logic [1:0] kind, input logic [7:0] addr,
                              input logic [7:0] reg_addr, input logic [7:0] wbyte,
                              input logic [7:0] count);
    offer_tick(kind, addr, reg_addr, wbyte, count);
    while (bus_phase != i2cmra_pkg::PH_IDLE)
      offer_tick(2'($urandom_range(3)), 8'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom));
  endtask

  // Random transfer; most reads are short, a few run longer
  task automatic random_transfer();
    logic [7:0] count;
    if ($urandom_range(39) == 0) count = 8'($urandom_range(5, 8));
    else count = 8'($urandom_range(0, 4));
    // Transfers that will fail never reach the data: full-range count is safe
    if ($urandom_range(9) == 0) count = 8'($urandom);
    if (count > 8'd20) begin
      busy_pct = 100;
    end
    run_transfer($urandom_range(1) ? i2cmra_pkg::KIND_READ : i2cmra_pkg::KIND_WRITE,
                 8'($urandom), 8'($urandom), 8'($urandom), count);
  endtask

  // -------------------------------------------------------------------------
  // Result side: stall pattern plus an optional long hold-off
  // -------------------------------------------------------------------------
  int unsigned ready_run = 0;
  int unsigned stall_run = 0;
  int unsigned hold_left = 0;
  int unsigned hold_seen = 0;

  always @(posedge clk) begin
    if (hold_kick != hold_seen) begin
      hold_seen = hold_kick;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!stalls_on) begin
      out_tready <= 1'b1;
    end else if (ready_run > 0) begin
      ready_run--;
      out_tready <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run--;
      out_tready <= 1'b0;
    end else begin
      ready_run = $urandom_range(0, 12);
      stall_run = $urandom_range(0, 4);
      out_tready <= 1'b0;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("tb: result %0d: %s got 0x%0h, want 0x%0h", result_count, what, got, want);
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Compare each taken result with the oldest prediction
  always @(posedge clk) begin : check_results
    i2cmra_pkg::tick_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, 0);
      end else begin
        e = pending_results.pop_front();
        check_field("scl_level", out_tdata[0], e.scl_level);
        check_field("sda_level", out_tdata[1], e.sda_level);
        check_field("read_byte", out_tdata[9:2], e.read_byte);
        check_field("read_valid", out_tdata[10], e.read_valid);
        check_field("done_res", out_tdata[11], e.done_res);
        check_field("success", out_tdata[12], e.success);
        check_field("busy_res", out_tdata[13], e.busy_res);
        check_field("pad bits", out_tdata[15:14], 0);
        check_field("last_byte", out_tlast, e.last_byte);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Plain ticks out of reset, both tick kinds, random SDA levels
  task automatic test_idle_ticks();
    offer_tick(i2cmra_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_tick(KIND_SPARE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    offer_tick(i2cmra_pkg::KIND_TICK, 8'hA5, 8'h5A, 8'h3C, 8'hC3);
    offer_tick(KIND_SPARE, 8'h00, 8'hFF, 8'h00, 8'hFF);
  endtask

  // Writes with all-zero and all-one operands, everything acked
  task automatic test_write_edges();
    busy_pct = 0;
    nack_pct = 0;
    run_transfer(i2cmra_pkg::KIND_WRITE, 8'h00, 8'h00, 8'h00, 8'h00);
    run_transfer(i2cmra_pkg::KIND_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
  endtask

  // Reads of zero, one and a few bytes
  task automatic test_read_lengths();
    busy_pct = 0;
    nack_pct = 0;
    run_transfer(i2cmra_pkg::KIND_READ, 8'hA0, 8'h10, 8'h00, 8'd0);
    run_transfer(i2cmra_pkg::KIND_READ, 8'h51, 8'hEF, 8'hFF, 8'd1);
    run_transfer(i2cmra_pkg::KIND_READ, 8'hFE, 8'h01, 8'h55, 8'd3);
  endtask

  // Start with SDA held low by someone else: immediate failure, no stop
  task automatic test_bus_busy();
    busy_pct = 100;
    run_transfer(i2cmra_pkg::KIND_WRITE, 8'h00, 8'hFF, 8'h00, 8'hFF);
    run_transfer(i2cmra_pkg::KIND_READ, 8'hFF, 8'h00, 8'hFF, 8'h80);
    busy_pct = 0;
  endtask

  // Address not acknowledged: stop and fail
  task automatic test_address_nack();
    nack_pct = 100;
    run_transfer(i2cmra_pkg::KIND_WRITE, 8'h3C, 8'h12, 8'h34, 8'h00);
    run_transfer(i2cmra_pkg::KIND_READ, 8'hC3, 8'h21, 8'h43, 8'hFF);
    nack_pct = 0;
  endtask

  // Hold the result side off long enough that the block stalls its input
  task automatic test_backpressure();
    gaps_on   = 1'b0;
    stalls_on = 1'b1;
    hold_len  = 300;
    hold_kick++;
    random_transfer();
  endtask

  // Mostly well-formed transfers with random content, some refusals
  task automatic test_random_traffic();
    int unsigned start_ticks;
    int unsigned idle_n;
    start_ticks = tick_count;
    while (tick_count - start_ticks < RANDOM_TICKS) begin
      gaps_on   = ($urandom_range(4) != 0);
      stalls_on = ($urandom_range(4) != 0);
      busy_pct  = 8;
      nack_pct  = 12;
      random_transfer();
      idle_n = $urandom_range(0, 3);
      repeat (idle_n)
        offer_tick($urandom_range(1) ? i2cmra_pkg::KIND_TICK : KIND_SPARE, 8'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic wait_drain();
    int unsigned guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", pending_results.size(), 0);
  endtask

  initial begin
    bus_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_ticks();
    test_write_edges();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    test_read_lengths();
    test_bus_busy();
    test_address_nack();
    test_backpressure();
    test_random_traffic();
    wait_drain();

    $display("tb: %0d ticks checked; %0d writes and %0d reads completed, %0d bytes read",
             result_count, writes_done, reads_done, bytes_rx);
    $display("tb: %0d transfers refused (bus busy or address NACK), %0d mismatches",
             refused, err_count);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
